// File: sv/centroid_cosine_accumulator_top_defines.svh
// Assertion helpers for the centroid cosine accumulator.
// Both expect clk and rst_n in scope.
`ifndef CENTROID_COSINE_ACCUMULATOR_TOP_DEFINES_SVH
`define CENTROID_COSINE_ACCUMULATOR_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CCA_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CCA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/cca_pkg.sv
package cca_pkg;

    localparam int DIMENSIONS_DEF    = 1024;
    localparam int FRACTION_BITS_DEF = 15;

    localparam int IDX_W   = 10;
    localparam int VAL_W   = 16;
    localparam int ACC_W   = 40;
    localparam int CNT_W   = 20;
    localparam int SQS_W   = 64;
    localparam int DOT_W   = 64;
    localparam int VSQ_W   = 48;
    localparam int COS_W   = 16;
    localparam int PROD_W  = ACC_W + VAL_W;
    localparam int VV_W    = 2 * VAL_W;
    localparam int ROOT_W  = SQS_W / 2;
    localparam int VROOT_W = VSQ_W / 2;
    localparam int DEN_W   = ROOT_W + VROOT_W;
    localparam int NUM_W   = DOT_W;

    localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
    localparam logic [SQS_W-1:0] SQS_MAX = {SQS_W{1'b1}};
    localparam logic [VSQ_W-1:0] VSQ_MAX = {VSQ_W{1'b1}};
    localparam logic [DOT_W-1:0] DOT_MAX = {1'b0, {(DOT_W-1){1'b1}}};
    localparam logic [DOT_W-1:0] DOT_MIN = {1'b1, {(DOT_W-1){1'b0}}};
    localparam logic [ACC_W-1:0] COS_CAP_POS = ACC_W'(32767);
    localparam logic [ACC_W-1:0] COS_CAP_NEG = ACC_W'(32768);

    typedef enum logic [1:0] {
        OP_SCORE = 2'd0,
        OP_ADD   = 2'd1,
        OP_NORM  = 2'd2,
        OP_CLEAR = 2'd3
    } op_t;

    typedef struct packed {
        logic [1:0]              operation;
        logic [IDX_W-1:0]        index;
        logic signed [VAL_W-1:0] value;
        logic                    last;
    } in_item_t;

    typedef struct packed {
        logic signed [COS_W-1:0] cosine;
        logic                    status;
        logic [CNT_W-1:0]        vector_count;
    } out_item_t;

    typedef enum logic [4:0] {
        ACT_NONE,
        ACT_LOAD,
        ACT_READ_ITEM,
        ACT_READ_PTR,
        ACT_SCORE_MUL,
        ACT_SCORE_ACC,
        ACT_ADD_WRITE,
        ACT_ZERO_WRITE,
        ACT_REC_SQ,
        ACT_REC_ADD,
        ACT_SQRT_S_START,
        ACT_SQRT_V_START,
        ACT_SQRT_S_SAVE,
        ACT_SQRT_V_SAVE,
        ACT_DEN,
        ACT_DIV_COS_START,
        ACT_COS_CAP,
        ACT_DIV_NORM_START,
        ACT_NORM_WRITE,
        ACT_SET_COUNT_ONE,
        ACT_CLEAR_REGS,
        ACT_RES_COS,
        ACT_RES_OK,
        ACT_RES_FAIL
    } act_t;

    typedef struct packed {
        act_t act;
    } cmd_t;

    typedef struct packed {
        op_t  op;
        logic last;
        logic sweep_last;
        logic busy;
        logic count_zero;
        logic root_zero;
        logic empty;
    } stat_t;

endpackage

// File: sv/cca_isqrt.sv
module cca_isqrt (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [cca_pkg::SQS_W-1:0]     x,
    output logic                          busy,
    output logic [cca_pkg::ROOT_W-1:0]    root
);

    localparam int STEP_W = $clog2(cca_pkg::ROOT_W);

    logic                       busy_reg;
    logic [STEP_W-1:0]          step_reg;
    logic [cca_pkg::SQS_W-1:0]  rem_reg;
    logic [cca_pkg::SQS_W-1:0]  res_reg;
    logic [cca_pkg::SQS_W-1:0]  bit_reg;
    logic [cca_pkg::SQS_W-1:0]  trial;
    logic                       take;

    assign trial = res_reg + bit_reg;
    assign take  = (rem_reg >= trial);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            step_reg <= '0;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(cca_pkg::ROOT_W - 1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // One result bit per cycle, two radicand bits consumed
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= x;
            res_reg <= '0;
            bit_reg <= {2'b01, {(cca_pkg::SQS_W-2){1'b0}}};
        end
        else if (busy_reg)
        begin
            if (take)
            begin
                rem_reg <= rem_reg - trial;
                res_reg <= (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    assign busy = busy_reg;
    assign root = res_reg[cca_pkg::ROOT_W-1:0];

endmodule

// File: sv/cca_divider.sv
module cca_divider #(
    parameter int FRACTION_BITS = cca_pkg::FRACTION_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [cca_pkg::NUM_W-1:0]     num,
    input  logic [cca_pkg::DEN_W-1:0]     den,
    output logic                          busy,
    output logic [cca_pkg::ACC_W-1:0]     quot,
    output logic                          ovf
);

    localparam int NB  = cca_pkg::NUM_W + FRACTION_BITS;
    localparam int CW  = $clog2(NB + 1);
    localparam int DW  = cca_pkg::DEN_W;
    localparam int QW  = cca_pkg::ACC_W;

    logic            busy_reg;
    logic [CW-1:0]   cnt_reg;
    logic [NB-1:0]   dvd_reg;
    logic [DW-1:0]   den_reg;
    logic [DW-1:0]   rem_reg;
    logic [QW-1:0]   q_reg;
    logic            ovf_reg;
    logic [DW:0]     rem_sh;
    logic [DW:0]     rem_sub;
    logic            ge;

    assign rem_sh  = {rem_reg, dvd_reg[NB-1]};
    assign rem_sub = rem_sh - {1'b0, den_reg};
    assign ge      = (rem_sh >= {1'b0, den_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CW'(NB);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // Restoring division of num * 2^FRACTION_BITS; quotient bits above QW go sticky
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= {num, {FRACTION_BITS{1'b0}}};
            den_reg <= den;
            rem_reg <= '0;
            q_reg   <= '0;
            ovf_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= dvd_reg << 1;
            rem_reg <= ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
            q_reg   <= {q_reg[QW-2:0], ge};
            ovf_reg <= ovf_reg | q_reg[QW-1];
        end
    end

    assign busy = busy_reg;
    assign quot = q_reg;
    assign ovf  = ovf_reg;

endmodule

// File: sv/cca_datapath.sv
module cca_datapath #(
    parameter int DIMENSIONS    = cca_pkg::DIMENSIONS_DEF,
    parameter int FRACTION_BITS = cca_pkg::FRACTION_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  cca_pkg::in_item_t    item_in,
    input  cca_pkg::cmd_t        cmd,
    output cca_pkg::stat_t       stat,
    output cca_pkg::out_item_t   res
);

    localparam int AW = $clog2(DIMENSIONS);

    logic signed [cca_pkg::ACC_W-1:0] mem [DIMENSIONS];
    logic signed [cca_pkg::ACC_W-1:0] rdata_reg;

    cca_pkg::in_item_t                item_reg;
    cca_pkg::out_item_t               res_reg;
    logic [AW-1:0]                    ptr_reg, ptr_next;
    logic [cca_pkg::CNT_W-1:0]        count_reg, count_next;
    logic [cca_pkg::SQS_W-1:0]        sqsum_reg, sqsum_next;
    logic [cca_pkg::SQS_W-1:0]        sum_reg, sum_next;
    logic signed [cca_pkg::DOT_W-1:0] dot_reg, dot_next;
    logic [cca_pkg::VSQ_W-1:0]        vsq_reg, vsq_next;

    logic signed [cca_pkg::PROD_W-1:0] prod_reg;
    logic [cca_pkg::VV_W-1:0]          vv_reg;
    logic [cca_pkg::SQS_W-1:0]         sq_reg;
    logic                              big_reg;
    logic [cca_pkg::ROOT_W-1:0]        rs_reg;
    logic [cca_pkg::VROOT_W-1:0]       rv_reg;
    logic [cca_pkg::DEN_W-1:0]         den_reg;
    logic                              empty_reg;
    logic signed [cca_pkg::COS_W-1:0]  cos_reg;

    cca_pkg::act_t                     act;
    logic signed [cca_pkg::VAL_W-1:0]  v_s;
    logic                              in_range;
    logic [AW-1:0]                     item_addr;
    logic signed [cca_pkg::ACC_W-1:0]  rd_val;
    logic signed [cca_pkg::PROD_W-1:0] prod_full;
    logic signed [cca_pkg::VV_W-1:0]   vv_full;
    logic signed [cca_pkg::DOT_W:0]    dot_sum;
    logic [cca_pkg::VSQ_W:0]           vsq_sum;
    logic signed [cca_pkg::ACC_W:0]    add_sum;
    logic signed [cca_pkg::ACC_W-1:0]  add_sat;
    logic [cca_pkg::ACC_W-1:0]         acc_mag;
    logic [cca_pkg::DOT_W-1:0]         dot_mag;
    logic [cca_pkg::SQS_W-1:0]         sq_full;
    logic [cca_pkg::SQS_W:0]           rec_sum;
    logic [cca_pkg::SQS_W-1:0]         rec_sat;
    logic [cca_pkg::DEN_W-1:0]         den_full;
    logic                              sweep_last;
    logic [AW-1:0]                     ptr_adv;

    logic                              mem_rd, mem_we;
    logic [AW-1:0]                     mem_raddr, mem_waddr;
    logic signed [cca_pkg::ACC_W-1:0]  mem_wdata;

    logic                              sqrt_start, sqrt_busy;
    logic [cca_pkg::SQS_W-1:0]         sqrt_x;
    logic [cca_pkg::ROOT_W-1:0]        root;
    logic                              div_start, div_busy, div_ovf;
    logic [cca_pkg::NUM_W-1:0]         div_num;
    logic [cca_pkg::DEN_W-1:0]         div_den;
    logic [cca_pkg::ACC_W-1:0]         quot;
    logic [cca_pkg::ACC_W-1:0]         cos_cap;
    logic [cca_pkg::ACC_W-1:0]         cos_q;
    logic [cca_pkg::ACC_W-1:0]         norm_q;
    logic signed [cca_pkg::ACC_W-1:0]  norm_val;

    assign act        = cmd.act;
    assign v_s        = item_reg.value;
    assign in_range   = (32'(item_reg.index) < 32'(DIMENSIONS));
    assign item_addr  = AW'(item_reg.index);
    assign rd_val     = in_range ? rdata_reg : '0;
    assign prod_full  = rd_val * v_s;
    assign vv_full    = v_s * v_s;
    assign dot_sum    = dot_reg + prod_reg;
    assign vsq_sum    = vsq_reg + vv_reg;
    assign add_sum    = rdata_reg + v_s;
    assign acc_mag    = rdata_reg[cca_pkg::ACC_W-1] ? -rdata_reg : rdata_reg;
    assign dot_mag    = dot_reg[cca_pkg::DOT_W-1] ? -dot_reg : dot_reg;
    assign sq_full    = acc_mag[cca_pkg::ROOT_W-1:0] * acc_mag[cca_pkg::ROOT_W-1:0];
    assign rec_sum    = {1'b0, sum_reg} + {1'b0, sq_reg};
    assign rec_sat    = (big_reg || rec_sum[cca_pkg::SQS_W]) ? cca_pkg::SQS_MAX
                                                             : rec_sum[cca_pkg::SQS_W-1:0];
    assign den_full   = rs_reg * rv_reg;
    assign sweep_last = (ptr_reg == AW'(DIMENSIONS - 1));
    assign ptr_adv    = sweep_last ? '0 : ptr_reg + AW'(1);

    always_comb
    begin
        if (add_sum[cca_pkg::ACC_W] != add_sum[cca_pkg::ACC_W-1])
        begin
            add_sat = add_sum[cca_pkg::ACC_W] ? cca_pkg::ACC_MIN : cca_pkg::ACC_MAX;
        end
        else
        begin
            add_sat = add_sum[cca_pkg::ACC_W-1:0];
        end
    end

    // Capping of the divider result for both users
    assign cos_cap  = dot_reg[cca_pkg::DOT_W-1] ? cca_pkg::COS_CAP_NEG : cca_pkg::COS_CAP_POS;
    assign cos_q    = (div_ovf || quot > cos_cap) ? cos_cap : quot;
    assign norm_q   = (div_ovf || quot > cca_pkg::ACC_MAX) ? cca_pkg::ACC_MAX : quot;
    assign norm_val = rdata_reg[cca_pkg::ACC_W-1] ? -norm_q : norm_q;

    assign sqrt_start = (act == cca_pkg::ACT_SQRT_S_START) || (act == cca_pkg::ACT_SQRT_V_START);
    assign sqrt_x     = (act == cca_pkg::ACT_SQRT_V_START) ? cca_pkg::SQS_W'(vsq_reg) : sqsum_reg;
    assign div_start  = (act == cca_pkg::ACT_DIV_COS_START) ||
                        (act == cca_pkg::ACT_DIV_NORM_START);
    assign div_num    = (act == cca_pkg::ACT_DIV_NORM_START) ? cca_pkg::NUM_W'(acc_mag)
                                                              : dot_mag;
    assign div_den    = (act == cca_pkg::ACT_DIV_NORM_START) ? cca_pkg::DEN_W'(rs_reg)
                                                              : den_reg;

    cca_isqrt u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sqrt_start),
        .x     (sqrt_x),
        .busy  (sqrt_busy),
        .root  (root)
    );

    cca_divider #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .busy  (div_busy),
        .quot  (quot),
        .ovf   (div_ovf)
    );

    // Memory port control
    always_comb
    begin
        mem_rd    = 1'b0;
        mem_raddr = ptr_reg;
        mem_we    = 1'b0;
        mem_waddr = ptr_reg;
        mem_wdata = '0;
        case (act)
            cca_pkg::ACT_READ_ITEM:
            begin
                mem_rd    = 1'b1;
                mem_raddr = item_addr;
            end
            cca_pkg::ACT_READ_PTR:
            begin
                mem_rd = 1'b1;
            end
            cca_pkg::ACT_ADD_WRITE:
            begin
                mem_we    = in_range;
                mem_waddr = item_addr;
                mem_wdata = add_sat;
            end
            cca_pkg::ACT_ZERO_WRITE:
            begin
                mem_we = 1'b1;
            end
            cca_pkg::ACT_NORM_WRITE:
            begin
                mem_we    = 1'b1;
                mem_wdata = norm_val;
            end
            default:
            begin
                mem_rd = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_rd)
        begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    // Centroid state
    always_comb
    begin
        ptr_next   = ptr_reg;
        count_next = count_reg;
        sqsum_next = sqsum_reg;
        sum_next   = sum_reg;
        dot_next   = dot_reg;
        vsq_next   = vsq_reg;
        case (act)
            cca_pkg::ACT_SCORE_ACC:
            begin
                if (dot_sum[cca_pkg::DOT_W] != dot_sum[cca_pkg::DOT_W-1])
                begin
                    dot_next = dot_sum[cca_pkg::DOT_W] ? cca_pkg::DOT_MIN : cca_pkg::DOT_MAX;
                end
                else
                begin
                    dot_next = dot_sum[cca_pkg::DOT_W-1:0];
                end
                vsq_next = vsq_sum[cca_pkg::VSQ_W] ? cca_pkg::VSQ_MAX
                                                   : vsq_sum[cca_pkg::VSQ_W-1:0];
            end
            cca_pkg::ACT_ADD_WRITE:
            begin
                if (item_reg.last && count_reg != cca_pkg::CNT_MAX)
                begin
                    count_next = count_reg + cca_pkg::CNT_W'(1);
                end
            end
            cca_pkg::ACT_ZERO_WRITE, cca_pkg::ACT_NORM_WRITE:
            begin
                ptr_next = ptr_adv;
            end
            cca_pkg::ACT_REC_ADD:
            begin
                ptr_next = ptr_adv;
                if (sweep_last)
                begin
                    sqsum_next = rec_sat;
                    sum_next   = '0;
                end
                else
                begin
                    sum_next = rec_sat;
                end
            end
            cca_pkg::ACT_SET_COUNT_ONE:
            begin
                count_next = cca_pkg::CNT_W'(1);
            end
            cca_pkg::ACT_CLEAR_REGS:
            begin
                count_next = '0;
                sqsum_next = '0;
                dot_next   = '0;
                vsq_next   = '0;
            end
            cca_pkg::ACT_RES_COS:
            begin
                dot_next = '0;
                vsq_next = '0;
            end
            default:
            begin
                ptr_next = ptr_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg   <= '0;
            count_reg <= '0;
            sqsum_reg <= '0;
            sum_reg   <= '0;
            dot_reg   <= '0;
            vsq_reg   <= '0;
        end
        else
        begin
            ptr_reg   <= ptr_next;
            count_reg <= count_next;
            sqsum_reg <= sqsum_next;
            sum_reg   <= sum_next;
            dot_reg   <= dot_next;
            vsq_reg   <= vsq_next;
        end
    end

    // Working registers and result
    always_ff @(posedge clk)
    begin
        case (act)
            cca_pkg::ACT_LOAD:
            begin
                item_reg <= item_in;
            end
            cca_pkg::ACT_SCORE_MUL:
            begin
                prod_reg <= prod_full;
                vv_reg   <= vv_full;
            end
            cca_pkg::ACT_REC_SQ:
            begin
                sq_reg  <= sq_full;
                big_reg <= |acc_mag[cca_pkg::ACC_W-1:cca_pkg::ROOT_W];
            end
            cca_pkg::ACT_SQRT_S_SAVE:
            begin
                rs_reg <= root;
            end
            cca_pkg::ACT_SQRT_V_SAVE:
            begin
                rv_reg <= root[cca_pkg::VROOT_W-1:0];
            end
            cca_pkg::ACT_DEN:
            begin
                den_reg   <= den_full;
                empty_reg <= (count_reg == '0) || (rs_reg == '0) || (rv_reg == '0);
            end
            cca_pkg::ACT_COS_CAP:
            begin
                cos_reg <= dot_reg[cca_pkg::DOT_W-1] ? -cos_q[cca_pkg::COS_W-1:0]
                                                     : cos_q[cca_pkg::COS_W-1:0];
            end
            cca_pkg::ACT_RES_COS:
            begin
                res_reg.cosine       <= empty_reg ? '0 : cos_reg;
                res_reg.status       <= empty_reg;
                res_reg.vector_count <= count_reg;
            end
            cca_pkg::ACT_RES_OK:
            begin
                res_reg.cosine       <= '0;
                res_reg.status       <= 1'b0;
                res_reg.vector_count <= count_reg;
            end
            cca_pkg::ACT_RES_FAIL:
            begin
                res_reg.cosine       <= '0;
                res_reg.status       <= 1'b1;
                res_reg.vector_count <= count_reg;
            end
            default:
            begin
                cos_reg <= cos_reg;
            end
        endcase
    end

    assign stat.op         = cca_pkg::op_t'(item_reg.operation);
    assign stat.last       = item_reg.last;
    assign stat.sweep_last = sweep_last;
    assign stat.busy       = sqrt_busy | div_busy;
    assign stat.count_zero = (count_reg == '0);
    assign stat.root_zero  = (rs_reg == '0);
    assign stat.empty      = empty_reg;
    assign res             = res_reg;

endmodule

// File: sv/cca_ctrl.sv
module cca_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    output logic              result_valid,
    input  logic              result_ready,
    input  cca_pkg::stat_t    stat,
    output cca_pkg::cmd_t     cmd
);

    typedef enum logic [4:0] {
        S_INIT,
        S_IDLE,
        S_DISPATCH,
        S_SC_MUL,
        S_SC_ACC,
        S_SQS_START,
        S_SQS_WAIT,
        S_SQV_START,
        S_SQV_WAIT,
        S_DEN,
        S_SC_CHK,
        S_COS_WAIT,
        S_ADD_WR,
        S_REC_RD,
        S_REC_SQ,
        S_REC_ADD,
        S_NR_CHK,
        S_NR_ROOT_CHK,
        S_NR_RD,
        S_NR_DIV,
        S_NR_WAIT,
        S_NR_WR,
        S_NR_DONE,
        S_CLR_ZERO,
        S_CLR_REGS,
        S_RESULT
    } state_t;

    state_t        state_reg, state_next;
    cca_pkg::act_t res_act_reg, res_act_next;
    logic          item_ready_reg;
    logic          result_valid_reg, result_valid_next;
    cca_pkg::act_t act;

    always_comb
    begin
        state_next        = state_reg;
        res_act_next      = res_act_reg;
        result_valid_next = result_valid_reg && !result_ready;
        act               = cca_pkg::ACT_NONE;
        case (state_reg)
            S_INIT:
            begin
                act = cca_pkg::ACT_ZERO_WRITE;
                if (stat.sweep_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (item_valid && item_ready_reg)
                begin
                    act        = cca_pkg::ACT_LOAD;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                act = cca_pkg::ACT_READ_ITEM;
                case (stat.op)
                    cca_pkg::OP_SCORE: state_next = S_SC_MUL;
                    cca_pkg::OP_ADD:   state_next = S_ADD_WR;
                    cca_pkg::OP_NORM:  state_next = S_NR_CHK;
                    cca_pkg::OP_CLEAR: state_next = S_CLR_ZERO;
                    default:           state_next = S_IDLE;
                endcase
            end
            S_SC_MUL:
            begin
                act        = cca_pkg::ACT_SCORE_MUL;
                state_next = S_SC_ACC;
            end
            S_SC_ACC:
            begin
                act        = cca_pkg::ACT_SCORE_ACC;
                state_next = stat.last ? S_SQS_START : S_IDLE;
            end
            S_SQS_START:
            begin
                act        = cca_pkg::ACT_SQRT_S_START;
                state_next = S_SQS_WAIT;
            end
            S_SQS_WAIT:
            begin
                if (!stat.busy)
                begin
                    act        = cca_pkg::ACT_SQRT_S_SAVE;
                    state_next = (stat.op == cca_pkg::OP_NORM) ? S_NR_ROOT_CHK : S_SQV_START;
                end
            end
            S_SQV_START:
            begin
                act        = cca_pkg::ACT_SQRT_V_START;
                state_next = S_SQV_WAIT;
            end
            S_SQV_WAIT:
            begin
                if (!stat.busy)
                begin
                    act        = cca_pkg::ACT_SQRT_V_SAVE;
                    state_next = S_DEN;
                end
            end
            S_DEN:
            begin
                act        = cca_pkg::ACT_DEN;
                state_next = S_SC_CHK;
            end
            S_SC_CHK:
            begin
                res_act_next = cca_pkg::ACT_RES_COS;
                if (stat.empty)
                begin
                    state_next = S_RESULT;
                end
                else
                begin
                    act        = cca_pkg::ACT_DIV_COS_START;
                    state_next = S_COS_WAIT;
                end
            end
            S_COS_WAIT:
            begin
                if (!stat.busy)
                begin
                    act        = cca_pkg::ACT_COS_CAP;
                    state_next = S_RESULT;
                end
            end
            S_ADD_WR:
            begin
                act = cca_pkg::ACT_ADD_WRITE;
                if (stat.last)
                begin
                    res_act_next = cca_pkg::ACT_RES_OK;
                    state_next   = S_REC_RD;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_REC_RD:
            begin
                act        = cca_pkg::ACT_READ_PTR;
                state_next = S_REC_SQ;
            end
            S_REC_SQ:
            begin
                act        = cca_pkg::ACT_REC_SQ;
                state_next = S_REC_ADD;
            end
            S_REC_ADD:
            begin
                act        = cca_pkg::ACT_REC_ADD;
                state_next = stat.sweep_last ? S_RESULT : S_REC_RD;
            end
            S_NR_CHK:
            begin
                if (stat.count_zero)
                begin
                    res_act_next = cca_pkg::ACT_RES_FAIL;
                    state_next   = S_RESULT;
                end
                else
                begin
                    act        = cca_pkg::ACT_SQRT_S_START;
                    state_next = S_SQS_WAIT;
                end
            end
            S_NR_ROOT_CHK:
            begin
                if (stat.root_zero)
                begin
                    act          = cca_pkg::ACT_SET_COUNT_ONE;
                    res_act_next = cca_pkg::ACT_RES_FAIL;
                    state_next   = S_REC_RD;
                end
                else
                begin
                    res_act_next = cca_pkg::ACT_RES_OK;
                    state_next   = S_NR_RD;
                end
            end
            S_NR_RD:
            begin
                act        = cca_pkg::ACT_READ_PTR;
                state_next = S_NR_DIV;
            end
            S_NR_DIV:
            begin
                act        = cca_pkg::ACT_DIV_NORM_START;
                state_next = S_NR_WAIT;
            end
            S_NR_WAIT:
            begin
                if (!stat.busy)
                begin
                    state_next = S_NR_WR;
                end
            end
            S_NR_WR:
            begin
                act        = cca_pkg::ACT_NORM_WRITE;
                state_next = stat.sweep_last ? S_NR_DONE : S_NR_RD;
            end
            S_NR_DONE:
            begin
                act        = cca_pkg::ACT_SET_COUNT_ONE;
                state_next = S_REC_RD;
            end
            S_CLR_ZERO:
            begin
                act = cca_pkg::ACT_ZERO_WRITE;
                if (stat.sweep_last)
                begin
                    state_next = S_CLR_REGS;
                end
            end
            S_CLR_REGS:
            begin
                act          = cca_pkg::ACT_CLEAR_REGS;
                res_act_next = cca_pkg::ACT_RES_OK;
                state_next   = S_RESULT;
            end
            S_RESULT:
            begin
                // hold until the output register is free
                if (!result_valid_reg || result_ready)
                begin
                    act               = res_act_reg;
                    result_valid_next = 1'b1;
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_INIT;
            res_act_reg      <= cca_pkg::ACT_RES_OK;
            item_ready_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            res_act_reg      <= res_act_next;
            item_ready_reg   <= (state_next == S_IDLE);
            result_valid_reg <= result_valid_next;
        end
    end

    assign cmd.act      = act;
    assign item_ready   = item_ready_reg;
    assign result_valid = result_valid_reg;

endmodule

// File: sv/centroid_cosine_accumulator_top.sv
// Spherical k-means centroid with cosine scoring. After reset the block sweeps the
// accumulator memory to zero, one entry a cycle, before taking its first item. An
// add element is one read-modify-write of the accumulator memory, a score element
// one read. Closing a score vector adds two square roots and, unless the result is
// empty, a divide. Closing an add vector recomputes the square sum over the whole
// memory, reading, squaring and adding each entry in turn. Normalize with a nonzero
// count runs a square root and, unless the root is zero, one divide per entry,
// then the same recompute; clear sweeps the memory once more. A finished result
// waits in the output register while the next item is taken.
`include "centroid_cosine_accumulator_top_defines.svh"

module centroid_cosine_accumulator_top #(
    parameter int DIMENSIONS    = cca_pkg::DIMENSIONS_DEF,
    parameter int FRACTION_BITS = cca_pkg::FRACTION_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  cca_pkg::in_item_t    item,
    output logic                 result_valid,
    input  logic                 result_ready,
    output cca_pkg::out_item_t   result
);

    cca_pkg::cmd_t  cmd;
    cca_pkg::stat_t stat;

    cca_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .stat         (stat),
        .cmd          (cmd)
    );

    cca_datapath #(
        .DIMENSIONS    (DIMENSIONS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .item_in (item),
        .cmd     (cmd),
        .stat    (stat),
        .res     (result)
    );

    `CCA_ASSERT_SAME(a_units_idle_when_ready, item_ready, !stat.busy, "unit busy while taking items")
    `CCA_ASSERT_NEXT(a_transfer_leaves_idle, item_valid && item_ready, !item_ready, "ready held after transfer")
    `CCA_ASSERT_NEXT(a_result_raises_valid, cmd.act == cca_pkg::ACT_RES_COS || cmd.act == cca_pkg::ACT_RES_OK || cmd.act == cca_pkg::ACT_RES_FAIL, result_valid, "result written without valid")

endmodule
